### sv/isfe_pkg.sv
// ----------------------------------------------------------------------------
// isfe_pkg
// Types and constants shared by the ipv4 sort and filter engine modules.
// ----------------------------------------------------------------------------
package isfe_pkg;

    localparam int ADDR_W     = 32;
    localparam int CFG_DATA_W = 8;
    localparam int CFG_IDX_W  = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_OCTET  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_OCTET = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_VALUE  = 2'd3;

    // filter modes
    localparam logic [1:0] MODE_ALL       = 2'd0;
    localparam logic [1:0] MODE_FIRST     = 2'd1;
    localparam logic [1:0] MODE_FIRST_TWO = 2'd2;
    localparam logic [1:0] MODE_ANY       = 2'd3;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic              end_of_set;
    } item_t;

    typedef struct packed {
        logic [ADDR_W-1:0] sorted_address;
        logic              last_result;
        logic              none_matched;
        logic              overflowed;
    } result_t;

    // controller to datapath
    typedef struct packed {
        logic insert;      // insert the accepted address into the chain
        logic set_ovf;     // accepted address dropped, chain is full
        logic pop;         // shift the chain toward the head
        logic load_out;    // head address into the result register
        logic load_empty;  // empty marker into the result register
        logic last;        // loaded result closes the run
        logic clear;       // run done, empty chain and overflow flag
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic full;
        logic any_match;
        logic head_match;
        logic rest_match;
        logic out_free;
    } status_t;

endpackage

### sv/isfe_ctrl.sv
// ----------------------------------------------------------------------------
// isfe_ctrl
// Load / drain sequencer for the sort and filter engine.
// ----------------------------------------------------------------------------
module isfe_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  logic              end_of_set,
    output logic              item_ready,
    input  isfe_pkg::status_t status,
    output isfe_pkg::cmd_t    cmd
);
    import isfe_pkg::*;

    typedef enum logic {
        ST_LOAD,
        ST_DRAIN
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        item_ready = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_LOAD:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.insert  = !status.full;
                    cmd.set_ovf = status.full;
                    if (end_of_set)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (!status.any_match)
                begin
                    if (status.out_free)
                    begin
                        cmd.load_empty = 1'b1;
                        cmd.last       = 1'b1;
                        cmd.clear      = 1'b1;
                        state_next     = ST_LOAD;
                    end
                end
                else if (status.head_match)
                begin
                    if (status.out_free)
                    begin
                        cmd.load_out = 1'b1;
                        cmd.pop      = 1'b1;
                        cmd.last     = !status.rest_match;
                        if (!status.rest_match)
                        begin
                            cmd.clear  = 1'b1;
                            state_next = ST_LOAD;
                        end
                    end
                end
                else
                begin
                    // head fails the filter, discard it
                    cmd.pop = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### sv/isfe_datapath.sv
// ----------------------------------------------------------------------------
// isfe_datapath
// Sorted cell chain, filter compare, config registers and result register.
// ----------------------------------------------------------------------------
module isfe_datapath #(
    parameter int CAPACITY = 64,
    parameter int CNT_W    = 7
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [isfe_pkg::ADDR_W-1:0]          item_address,
    input  logic                                 cfg_we,
    input  logic [isfe_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [isfe_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  isfe_pkg::cmd_t                       cmd,
    output isfe_pkg::status_t                    status,
    output logic                                 result_valid,
    input  logic                                 result_ready,
    output isfe_pkg::result_t                    result
);
    import isfe_pkg::*;

    logic [ADDR_W-1:0] cell_reg  [CAPACITY];
    logic [ADDR_W-1:0] cell_next [CAPACITY];
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              ovf_reg;
    logic              ovf_next;

    logic [1:0]        mode_reg;
    logic [7:0]        first_reg;
    logic [7:0]        second_reg;
    logic [7:0]        match_reg;

    logic              result_valid_reg;
    logic              result_valid_next;
    result_t           result_reg;
    result_t           result_next;

    logic [CAPACITY-1:0] occupied;
    logic [CAPACITY-1:0] gt;
    logic [CAPACITY-1:0] match;

    function automatic logic passes(
        input logic [ADDR_W-1:0] a,
        input logic [1:0]        mode,
        input logic [7:0]        first_v,
        input logic [7:0]        second_v,
        input logic [7:0]        any_v
    );
        logic ok;
        case (mode)
            MODE_ALL:       ok = 1'b1;
            MODE_FIRST:     ok = (a[31:24] == first_v);
            MODE_FIRST_TWO: ok = (a[31:24] == first_v) && (a[23:16] == second_v);
            MODE_ANY:       ok = (a[31:24] == any_v) || (a[23:16] == any_v) ||
                                 (a[15:8] == any_v) || (a[7:0] == any_v);
            default:        ok = 1'b1;
        endcase
        return ok;
    endfunction

    // per cell compare against the incoming address and the filter
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            occupied[i] = (CNT_W'(i) < count_reg);
            gt[i]       = !occupied[i] || (item_address > cell_reg[i]);
            match[i]    = occupied[i] &&
                          passes(cell_reg[i], mode_reg, first_reg, second_reg, match_reg);
        end
    end

    // the chain stays descending: cells at and past the insert point shift down
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        if (g == 0)
        begin : g_head
            always_comb
            begin
                cell_next[g] = cell_reg[g];
                if (cmd.insert && gt[g])
                begin
                    cell_next[g] = item_address;
                end
                else if (cmd.pop)
                begin
                    cell_next[g] = cell_reg[g+1];
                end
            end
        end
        else if (g == CAPACITY - 1)
        begin : g_tail
            always_comb
            begin
                cell_next[g] = cell_reg[g];
                if (cmd.insert && gt[g])
                begin
                    cell_next[g] = gt[g-1] ? cell_reg[g-1] : item_address;
                end
            end
        end
        else
        begin : g_mid
            always_comb
            begin
                cell_next[g] = cell_reg[g];
                if (cmd.insert && gt[g])
                begin
                    cell_next[g] = gt[g-1] ? cell_reg[g-1] : item_address;
                end
                else if (cmd.pop)
                begin
                    cell_next[g] = cell_reg[g+1];
                end
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (cmd.clear)
        begin
            count_next = '0;
            ovf_next   = 1'b0;
        end
        else
        begin
            if (cmd.insert)
            begin
                count_next = count_reg + CNT_W'(1);
            end
            else if (cmd.pop)
            begin
                count_next = count_reg - CNT_W'(1);
            end
            if (cmd.set_ovf)
            begin
                ovf_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        result_valid_next = result_valid_reg && !result_ready;
        result_next       = result_reg;
        if (cmd.load_out)
        begin
            result_valid_next          = 1'b1;
            result_next.sorted_address = cell_reg[0];
            result_next.last_result    = cmd.last;
            result_next.none_matched   = 1'b0;
            result_next.overflowed     = ovf_reg;
        end
        else if (cmd.load_empty)
        begin
            result_valid_next          = 1'b1;
            result_next.sorted_address = '0;
            result_next.last_result    = 1'b1;
            result_next.none_matched   = 1'b1;
            result_next.overflowed     = ovf_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            cell_reg[i] <= cell_next[i];
        end
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            ovf_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
            mode_reg         <= MODE_ALL;
            first_reg        <= '0;
            second_reg       <= '0;
            match_reg        <= '0;
        end
        else
        begin
            count_reg        <= count_next;
            ovf_reg          <= ovf_next;
            result_valid_reg <= result_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_FILTER_MODE:  mode_reg   <= cfg_data[1:0];
                    CFG_FIRST_OCTET:  first_reg  <= cfg_data;
                    CFG_SECOND_OCTET: second_reg <= cfg_data;
                    CFG_MATCH_VALUE:  match_reg  <= cfg_data;
                    default:          mode_reg   <= mode_reg;
                endcase
            end
        end
    end

    assign status.full       = (count_reg == CNT_W'(CAPACITY));
    assign status.any_match  = |match;
    assign status.head_match = match[0];
    assign status.rest_match = |match[CAPACITY-1:1];
    assign status.out_free   = !result_valid_reg || result_ready;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

### sv/ipv4_sort_filter_engine_core.sv
// ----------------------------------------------------------------------------
// ipv4_sort_filter_engine_core
// Collects a set of ipv4 addresses and returns the filtered ones in
// descending order.
// ----------------------------------------------------------------------------
// usage
//   item channel: one address per beat, taken one per cycle while loading;
//   the beat with end_of_set closes the set. addresses past CAPACITY are
//   dropped and reported through overflowed on every result of the run.
//   an address goes straight into a sorted chain of CAPACITY cells.
//   result channel: after the closing beat the chain drains from its head,
//   one cell per cycle unless a matching cell waits on a stalled receiver;
//   a matching cell yields a result beat, a failing one is discarded with
//   no beat. when nothing passes the filter a single beat with none_matched
//   comes out.
//   item_ready is low while draining and high again once the final result
//   is in the output register, so the next set may load while it waits.
//   a stalled receiver holds the result register and pauses the drain at the next matching cell.
//   config writes (cfg_we) are taken at any time but belong in idle gaps.
//   reset empties the chain, clears the overflow flag, the result valid flag and the config registers.
// ----------------------------------------------------------------------------
module ipv4_sort_filter_engine_core #(
    parameter int CAPACITY = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_valid,
    output logic                             item_ready,
    input  isfe_pkg::item_t                  item,
    output logic                             result_valid,
    input  logic                             result_ready,
    output isfe_pkg::result_t                result,
    input  logic                             cfg_we,
    input  logic [isfe_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [isfe_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import isfe_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    cmd_t    cmd;
    status_t status;

    isfe_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .end_of_set (item.end_of_set),
        .item_ready (item_ready),
        .status     (status),
        .cmd        (cmd)
    );

    isfe_datapath #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_address (item.address),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
